FILE: design/page_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Page bitmap allocator assertion macros
// Shared concurrent assertion forms for the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page bitmap allocator assertion failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page bitmap allocator assertion failed");

`endif

FILE: design/pba_pkg.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Operation and status codes, beat payload types and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int DEF_PAGES_PER_FILE = 4;
    localparam int DEF_MAX_FILES      = 256;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] file_number;
        logic [1:0] page_number;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_file;
        logic [1:0] granted_page;
    } t_resp;

endpackage

`default_nettype wire

FILE: design/pba_if.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator channels
// Valid/ready request and response channels with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_req_if;
    logic          valid;
    logic          ready;
    pba_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pba_resp_if;
    logic           valid;
    logic           ready;
    pba_pkg::t_resp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page allocator over a per-file bitmap held in one synchronous
// memory, with a count of files opened so far.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Beat
//  i_req    in   operation, file_number, page_number       valid & ready
//  o_res    out  status, granted_file, granted_page        valid & ready
//
//  Free and check read the file's entry (S_RD, S_EVAL); out of range or the
//  unused code go straight to S_RESP. Allocate scans open files through the single
//  read port (S_RD, S_EVAL per file) and opens a new file in S_NEW if none is free.
//  One request is in flight at a time; a stalled response holds the block.
//  Reset clears the file count; bitmap entries are written when a file opens.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator #(
    parameter int PAGES_PER_FILE = pba_pkg::DEF_PAGES_PER_FILE,
    parameter int MAX_FILES      = pba_pkg::DEF_MAX_FILES
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pba_req_if.sink      i_req,
    pba_resp_if.source   o_res
);

    localparam int P    = PAGES_PER_FILE;
    localparam int AW   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CW   = $clog2(MAX_FILES + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int PW   = (P > 1) ? $clog2(P) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_NEW  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [P-1:0]   mem [MAX_FILES];

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_out_valid, n_out_valid;
    pba_pkg::t_resp r_out, n_out;
    logic [1:0]     r_op, n_op;
    logic [1:0]     r_page, n_page;
    logic [AW-1:0]  r_addr, n_addr;
    logic [1:0]     r_pend, n_pend;
    logic [P-1:0]   r_rd_data;

    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [P-1:0]   w_wdata;

    logic           req_fire;
    logic           out_free;
    logic           in_range;
    logic           found;
    logic [PW-1:0]  free_idx;
    logic [P-1:0]   mask;
    logic           last_file;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign in_range  = (CMPW'(i_req.data.file_number) < CMPW'(r_count))
                    && (int'(i_req.data.page_number) < P);
    assign mask      = P'(1) << r_page;
    assign last_file = (CW'(r_addr) + CW'(1)) == r_count;

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = P - 1; i >= 0; i--) begin
            if (!r_rd_data[i]) begin
                found    = 1'b1;
                free_idx = PW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = (r_out_valid && !o_res.ready);
        n_op        = r_op;
        n_page      = r_page;
        n_addr      = r_addr;
        n_pend      = r_pend;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op   = i_req.data.operation;
                    n_page = i_req.data.page_number;
                    unique case (i_req.data.operation)
                        pba_pkg::OP_ALLOC: begin
                            n_addr  = '0;
                            n_state = (r_count == '0) ? S_NEW : S_RD;
                        end
                        pba_pkg::OP_FREE: begin
                            n_addr  = AW'(i_req.data.file_number);
                            n_pend  = pba_pkg::ST_IGNORED;
                            n_state = in_range ? S_RD : S_RESP;
                        end
                        pba_pkg::OP_CHECK: begin
                            n_addr  = AW'(i_req.data.file_number);
                            n_pend  = pba_pkg::ST_NOT_ALLOC;
                            n_state = in_range ? S_RD : S_RESP;
                        end
                        default: begin
                            n_pend  = pba_pkg::ST_IGNORED;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                unique case (r_op)
                    pba_pkg::OP_ALLOC: begin
                        if (found) begin
                            if (out_free) begin
                                w_we        = 1'b1;
                                w_wdata     = r_rd_data | (P'(1) << free_idx);
                                n_out       = '{pba_pkg::ST_OK, 8'(r_addr), 2'(free_idx)};
                                n_out_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else if (last_file) begin
                            n_state = S_NEW;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_state = S_RD;
                        end
                    end
                    pba_pkg::OP_FREE: begin
                        if (out_free) begin
                            w_we        = 1'b1;
                            w_wdata     = r_rd_data & ~mask;
                            n_out       = '{pba_pkg::ST_OK, 8'd0, 2'd0};
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    pba_pkg::OP_CHECK: begin
                        if (out_free) begin
                            n_out       = '{((r_rd_data & mask) != '0) ? pba_pkg::ST_OK
                                            : pba_pkg::ST_NOT_ALLOC, 8'd0, 2'd0};
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_out       = '{pba_pkg::ST_IGNORED, 8'd0, 2'd0};
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            S_NEW: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_count == CW'(MAX_FILES)) begin
                        n_out = '{pba_pkg::ST_NO_SPACE, 8'd0, 2'd0};
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_count);
                        w_wdata = P'(1);
                        n_count = r_count + CW'(1);
                        n_out   = '{pba_pkg::ST_OK, 8'(r_count), 2'd0};
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out       = '{r_pend, 8'd0, 2'd0};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_op   <= n_op;
        r_page <= n_page;
        r_addr <= n_addr;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

endmodule

`default_nettype wire

FILE: design/pba_checker.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Port-level assertions on request and response beats, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_bitmap_allocator_macros.svh"

module pba_checker #(
    parameter int PAGES_PER_FILE = pba_pkg::DEF_PAGES_PER_FILE
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_req_valid,
    input wire                 i_req_ready,
    input wire                 i_res_valid,
    input wire                 i_res_ready,
    input wire pba_pkg::t_resp i_res_data
);

    `PBA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    `PBA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data))

    `PBA_ASSERT_NOW(a_grant_zero, i_clk, i_rst_n, i_res_valid && (i_res_data.status != pba_pkg::ST_OK), (i_res_data.granted_file == 8'd0) && (i_res_data.granted_page == 2'd0))

    `PBA_ASSERT_NOW(a_page_range, i_clk, i_rst_n, i_res_valid, int'(i_res_data.granted_page) < PAGES_PER_FILE)

endmodule

bind page_bitmap_allocator pba_checker #(
    .PAGES_PER_FILE(PAGES_PER_FILE)
) u_pba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire

FILE: tb/page_bitmap_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Watches the request and response channels, keeps its own copy of the page
// bitmap and the open-file count, predicts each reply in order and compares
// it field by field with the reply the block returns.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_checker (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    input  wire            i_req_ready,
    input  pba_pkg::t_req  i_req_data,
    input  wire            i_res_valid,
    input  wire            i_res_ready,
    input  pba_pkg::t_resp i_res_data,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int PAGES = pba_pkg::DEF_PAGES_PER_FILE;
    localparam int FILES = pba_pkg::DEF_MAX_FILES;
    localparam int FW    = $clog2(FILES + 1);

    logic [PAGES-1:0] page_map [FILES];
    logic [FW-1:0]    files_open;
    pba_pkg::t_resp   expected_replies [$];
    int               mismatch_total = 0;

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit page_in_range(input logic [7:0] file, input logic [1:0] page);
        return int'(file) < int'(files_open) && int'(page) < PAGES;
    endfunction

    function automatic pba_pkg::t_resp predict_reply(input pba_pkg::t_req r);
        pba_pkg::t_resp reply;
        bit             granted;
        reply   = '0;
        granted = 1'b0;
        case (r.operation)
            pba_pkg::OP_ALLOC: begin
                for (int f = 0; f < FILES; f++) begin
                    for (int p = 0; p < PAGES; p++) begin
                        if (!granted && f < int'(files_open) && !page_map[f][p]) begin
                            page_map[f][p]     = 1'b1;
                            reply.status       = pba_pkg::ST_OK;
                            reply.granted_file = 8'(f);
                            reply.granted_page = 2'(p);
                            granted            = 1'b1;
                        end
                    end
                end
                if (!granted) begin
                    if (int'(files_open) >= FILES) begin
                        reply.status = pba_pkg::ST_NO_SPACE;
                    end else begin
                        page_map[files_open] = PAGES'(1);
                        reply.status         = pba_pkg::ST_OK;
                        reply.granted_file   = files_open[7:0];
                        files_open           = files_open + FW'(1);
                    end
                end
            end
            pba_pkg::OP_FREE: begin
                if (page_in_range(r.file_number, r.page_number)) begin
                    page_map[r.file_number][r.page_number] = 1'b0;
                    reply.status = pba_pkg::ST_OK;
                end else begin
                    reply.status = pba_pkg::ST_IGNORED;
                end
            end
            pba_pkg::OP_CHECK: begin
                if (page_in_range(r.file_number, r.page_number) &&
                    page_map[r.file_number][r.page_number]) begin
                    reply.status = pba_pkg::ST_OK;
                end else begin
                    reply.status = pba_pkg::ST_NOT_ALLOC;
                end
            end
            default: begin
                reply.status = pba_pkg::ST_IGNORED;
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        pba_pkg::t_resp want;
        if (!i_rst_n) begin
            for (int f = 0; f < FILES; f++) begin
                page_map[f] = '0;
            end
            files_open = '0;
            expected_replies.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply status=%0d file=%0d page=%0d",
                        i_res_data.status, i_res_data.granted_file, i_res_data.granted_page));
                end else begin
                    want = expected_replies.pop_front();
                    if (i_res_data.status !== want.status ||
                        i_res_data.granted_file !== want.granted_file ||
                        i_res_data.granted_page !== want.granted_page) begin
                        report_mismatch($sformatf(
                            "reply status=%0d file=%0d page=%0d, want %0d/%0d/%0d",
                            i_res_data.status, i_res_data.granted_file,
                            i_res_data.granted_page, want.status, want.granted_file,
                            want.granted_page));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_replies.push_back(predict_reply(i_req_data));
            end
        end
        o_pending    <= expected_replies.size();
        o_fail_count <= mismatch_total;
    end

endmodule

FILE: tb/page_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Resets the allocator once, runs directed corner requests, then random
// mixes that grow the file set, fill every page until the allocator runs
// out of space, and churn frees and allocates while full. Both channels
// stall at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         DRAIN_CYCLES = 2 * pba_pkg::DEF_MAX_FILES + 64;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic res_ready = 1'b0;
    logic calm      = 1'b0;
    logic saw_full  = 1'b0;
    int   cycle_count = 0;
    int   allocs_sent = 0;
    int   fail_count;
    int   pending;

    pba_req_if  req_ch ();
    pba_resp_if res_ch ();

    assign res_ch.ready = res_ready;

    page_bitmap_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    page_bitmap_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_data   (req_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready && res_ch.data.status == pba_pkg::ST_NO_SPACE) begin
            saw_full <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic pba_pkg::t_req page_request(input logic [1:0] op,
                                                   input logic [7:0] file,
                                                   input logic [1:0] page);
        pba_pkg::t_req r;
        r.operation   = op;
        r.file_number = file;
        r.page_number = page;
        return r;
    endfunction

    function automatic logic [7:0] pick_file();
        int hint;
        int r;
        hint = (allocs_sent / 3 + 1 > 255) ? 255 : allocs_sent / 3 + 1;
        r    = $urandom_range(0, 99);
        if (r < 70) begin
            return 8'($urandom_range(0, hint));
        end
        if (r < 85) begin
            return 8'($urandom_range(hint, 255));
        end
        return 8'($urandom);
    endfunction

    function automatic pba_pkg::t_req pick_item(input int alloc_pct, input int free_pct,
                                                input int check_pct);
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            op = pba_pkg::OP_ALLOC;
            allocs_sent++;
        end else if (r < alloc_pct + free_pct) begin
            op = pba_pkg::OP_FREE;
        end else if (r < alloc_pct + free_pct + check_pct) begin
            op = pba_pkg::OP_CHECK;
        end else begin
            op = OP_UNUSED;
        end
        return page_request(op, pick_file(), 2'($urandom_range(0, 3)));
    endfunction

    // present one beat, sometimes after a random gap; valid stays high on return
    task automatic send_req(input pba_pkg::t_req r);
        if (!calm && $urandom_range(0, 99) < 23) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= pba_pkg::t_req'(12'($urandom));
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // hold the sender until every reply is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(page_request(pba_pkg::OP_CHECK, 8'd0, 2'd0));
        send_req(page_request(pba_pkg::OP_FREE, 8'd0, 2'd0));
        send_req(page_request(OP_UNUSED, 8'd255, 2'd3));
        repeat (5) send_req(page_request(pba_pkg::OP_ALLOC, 8'd255, 2'd3));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd0, 2'd3));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd1, 2'd1));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd2, 2'd0));
        send_req(page_request(pba_pkg::OP_FREE, 8'd1, 2'd2));
        send_req(page_request(pba_pkg::OP_FREE, 8'd0, 2'd1));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd0, 2'd1));
        send_req(page_request(pba_pkg::OP_ALLOC, 8'd0, 2'd0));
        send_req(page_request(pba_pkg::OP_FREE, 8'd255, 2'd3));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd255, 2'd3));
        send_req(page_request(pba_pkg::OP_FREE, 8'd1, 2'd0));
        send_req(page_request(pba_pkg::OP_ALLOC, 8'd0, 2'd0));
        send_req(page_request(OP_UNUSED, 8'd0, 2'd0));
        send_req(page_request(pba_pkg::OP_ALLOC, 8'd170, 2'd2));
        send_req(page_request(pba_pkg::OP_CHECK, 8'd1, 2'd1));
        wait_drained();

        for (int i = 0; i < 350; i++) begin
            calm <= (i >= 120 && i < 220);
            send_req(pick_item(50, 25, 22));
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
        end
        calm <= 1'b0;
        wait_drained();

        // fill every page until the allocator reports no space
        for (int n = 0; n < 1150 && !saw_full; n++) begin
            send_req(pick_item(92, 0, 8));
        end
        wait_drained();

        for (int i = 0; i < 160; i++) begin
            send_req(pick_item(40, 34, 22));
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/pba_pkg.sv
design/pba_if.sv
design/page_bitmap_allocator.sv
design/pba_checker.sv
tb/page_bitmap_allocator_checker.sv
tb/page_bitmap_allocator_tb.sv
